FILE: sv/assert_macros.svh
// Assertion macros shared by the LED frame buffer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/ledfb_pkg.sv
// Package for the LED frame buffer symbol encoder: field widths, function codes,
// symbol table and the command/status structs between controller and datapath.
// No dependencies.
package ledfb_pkg;

	localparam int NUM_LEDS_DEF = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int COLOR_W = 24;
	localparam int SYM_W = 6;
	localparam int FUNC_W = 3;
	localparam int PAIR_W = 4;
	localparam int SYMS_PER_LED = 12;

	localparam logic [FUNC_W-1:0] FUNC_SET = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_FILL = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ = 3'd4;

	localparam logic [SYM_W-1:0] SYM_PAIR0 = 6'h37;
	localparam logic [SYM_W-1:0] SYM_PAIR1 = 6'h27;
	localparam logic [SYM_W-1:0] SYM_PAIR2 = 6'h36;
	localparam logic [SYM_W-1:0] SYM_PAIR3 = 6'h26;

	localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(SYMS_PER_LED - 1);

	typedef struct packed {
		logic clr_wr;
		logic set_wr;
		logic fill_start;
		logic fill_wr;
		logic flush;
		logic rd_issue;
		logic rd_tick;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic idx_ok;
		logic fill_ok;
		logic sending;
		logic fill_last;
		logic clr_last;
		logic out_free;
	} status_t;

	// Picks the bit pair for one symbol slot, most significant pair first.
	function automatic logic [SYM_W-1:0] pair_symbol(input logic [COLOR_W-1:0] c,
		input logic [PAIR_W-1:0] p);
		logic [4:0] sh;
		logic [1:0] b;
		sh = 5'd22 - {p, 1'b0};
		b = 2'(c >> sh);
		case (b)
			2'd0: pair_symbol = SYM_PAIR0;
			2'd1: pair_symbol = SYM_PAIR1;
			2'd2: pair_symbol = SYM_PAIR2;
			default: pair_symbol = SYM_PAIR3;
		endcase
	endfunction

endpackage

FILE: sv/ledfb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ledfb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: sv/ledfb_ctrl.sv
// Controller state machine of the LED frame buffer: clearing pass, request
// decode, fill walk and result hand-off. Depends on ledfb_pkg.
module ledfb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [ledfb_pkg::FUNC_W-1:0]  func,
	input  ledfb_pkg::status_t            st,
	output logic                          s_tready,
	output ledfb_pkg::cmd_t               cmd
);

	localparam logic [1:0] ST_CLR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_RDY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid & s_tready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (func)
						ledfb_pkg::FUNC_SET: begin
							cmd.set_wr = st.idx_ok;
						end
						ledfb_pkg::FUNC_FILL: begin
							if (st.fill_ok) begin
								cmd.fill_start = 1'b1;
								state_d = ST_FILL;
							end
						end
						ledfb_pkg::FUNC_FLUSH: begin
							cmd.flush = 1'b1;
						end
						ledfb_pkg::FUNC_TICK: begin
							if (st.sending) begin
								cmd.rd_issue = 1'b1;
								cmd.rd_tick = 1'b1;
								state_d = ST_RDY;
							end
						end
						ledfb_pkg::FUNC_READ: begin
							cmd.rd_issue = 1'b1;
							state_d = ST_RDY;
						end
						default: begin
						end
					endcase
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (st.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RDY: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/ledfb_dp.sv
// Datapath of the LED frame buffer: colour store, high-water mark, send
// counters, symbol encoding and output register. Depends on ledfb_pkg, ledfb_ram.
module ledfb_dp #(
	parameter int NUM_LEDS = ledfb_pkg::NUM_LEDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ledfb_pkg::IDX_W-1:0]     led_index,
	input  logic [ledfb_pkg::CNT_W-1:0]     fill_count,
	input  logic [ledfb_pkg::COLOR_W-1:0]   color,
	input  ledfb_pkg::cmd_t                 cmd,
	output ledfb_pkg::status_t              st,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic                            out_kind,
	output logic [ledfb_pkg::SYM_W-1:0]     out_symbol,
	output logic                            out_last,
	output logic [ledfb_pkg::COLOR_W-1:0]   out_color
);

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int CW = $clog2(NUM_LEDS + 1);
	localparam int SW = ((CW > ledfb_pkg::CNT_W) ? CW : ledfb_pkg::CNT_W) + 1;

	logic [SW-1:0]                  idx_ext;
	logic [SW-1:0]                  run_end;
	logic [CW-1:0]                  fill_end;
	logic [CW-1:0]                  set_end;
	logic [CW-1:0]                  mark_new;
	logic                           fin;

	logic                           ram_we;
	logic [AW-1:0]                  ram_addr;
	logic [ledfb_pkg::COLOR_W-1:0]  ram_wdata;
	logic [ledfb_pkg::COLOR_W-1:0]  ram_rdata;

	logic [AW-1:0]                  ptr_q;
	logic [CW-1:0]                  end_q;
	logic [ledfb_pkg::COLOR_W-1:0]  color_q;
	logic                           kind_q;
	logic                           oob_q;
	logic [CW-1:0]                  high_water_q;
	logic [CW-1:0]                  frame_length_q;
	logic [AW-1:0]                  send_led_q;
	logic [ledfb_pkg::PAIR_W-1:0]   send_pair_q;
	logic                           sending_q;
	logic                           m_tvalid_q;

	assign idx_ext = SW'(led_index);
	assign run_end = idx_ext + SW'(fill_count);
	assign fill_end = (run_end > SW'(NUM_LEDS)) ? CW'(NUM_LEDS) : CW'(run_end);
	assign set_end = CW'(idx_ext + SW'(1));
	assign mark_new = cmd.fill_start ? fill_end : set_end;

	assign fin = (send_pair_q == ledfb_pkg::PAIR_LAST)
		&& ((CW'(send_led_q) + CW'(1)) >= frame_length_q);

	assign st.idx_ok = idx_ext < SW'(NUM_LEDS);
	assign st.fill_ok = st.idx_ok && (fill_count != '0);
	assign st.sending = sending_q;
	assign st.fill_last = (CW'(ptr_q) + CW'(1)) == end_q;
	assign st.clr_last = ptr_q == AW'(NUM_LEDS - 1);
	assign st.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		ram_we = cmd.clr_wr | cmd.set_wr | cmd.fill_wr;
		ram_addr = ptr_q;
		if (cmd.set_wr || (cmd.rd_issue && !cmd.rd_tick)) begin
			ram_addr = AW'(led_index);
		end else if (cmd.rd_issue) begin
			ram_addr = send_led_q;
		end
		if (cmd.clr_wr) begin
			ram_wdata = '0;
		end else if (cmd.set_wr) begin
			ram_wdata = color;
		end else begin
			ram_wdata = color_q;
		end
	end

	ledfb_ram #(
		.WIDTH(ledfb_pkg::COLOR_W),
		.DEPTH(NUM_LEDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.fill_start) begin
			end_q <= fill_end;
			color_q <= color;
		end
		if (cmd.rd_issue) begin
			kind_q <= !cmd.rd_tick;
			oob_q <= !cmd.rd_tick && !st.idx_ok;
		end
		if (cmd.out_load) begin
			out_kind <= kind_q;
			if (kind_q) begin
				out_symbol <= '0;
				out_last <= 1'b0;
				out_color <= oob_q ? '0 : ram_rdata;
			end else begin
				out_symbol <= ledfb_pkg::pair_symbol(ram_rdata, send_pair_q);
				out_last <= fin;
				out_color <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			high_water_q <= '0;
			frame_length_q <= '0;
			send_led_q <= '0;
			send_pair_q <= '0;
			sending_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr || cmd.fill_wr) begin
				ptr_q <= ptr_q + AW'(1);
			end else if (cmd.fill_start) begin
				ptr_q <= AW'(led_index);
			end else if (cmd.rd_issue) begin
				ptr_q <= ram_addr;
			end
			if (cmd.set_wr || cmd.fill_start) begin
				if (mark_new > high_water_q) begin
					high_water_q <= mark_new;
				end
			end
			if (cmd.flush && !sending_q) begin
				high_water_q <= '0;
				if (high_water_q != '0) begin
					frame_length_q <= high_water_q;
					send_led_q <= '0;
					send_pair_q <= '0;
					sending_q <= 1'b1;
				end
			end
			if (cmd.out_load && !kind_q) begin
				if (fin) begin
					sending_q <= 1'b0;
					send_led_q <= '0;
					send_pair_q <= '0;
				end else if (send_pair_q == ledfb_pkg::PAIR_LAST) begin
					send_pair_q <= '0;
					send_led_q <= send_led_q + AW'(1);
				end else begin
					send_pair_q <= send_pair_q + ledfb_pkg::PAIR_W'(1);
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

FILE: sv/led_frame_buffer_symbol_encoder_unit.sv
// Top level of the LED frame buffer with 6-bit UART symbol encoder.
// Depends on ledfb_pkg, ledfb_ctrl, ledfb_dp, ledfb_ram and assert_macros.svh.
//
// Channel   Dir  tdata fields (low bit up)                   tuser / tlast
// s_*       in   led_index, fill_count, color (40 bits)      tuser: func
// m_*       out  symbol, read_color (32 bits)                tuser: result_kind, tlast: last
//
// Set and flush are handled in the idle state; a fill then writes each LED in turn in the fill state.
// Tick and read go through the registered store read and then the output register,
// which waits on m_tready.
// After reset the store is cleared one LED per cycle, over all NUM_LEDS entries, with
// s_tready low.
`include "assert_macros.svh"

module led_frame_buffer_symbol_encoder_unit #(
	parameter int NUM_LEDS = ledfb_pkg::NUM_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // led_index[5:0], fill_count[12:6], color[36:13]
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // symbol[5:0], read_color[29:6]
	output logic [0:0]  m_tuser,   // result_kind[0]
	output logic        m_tlast
);

	ledfb_pkg::cmd_t                      cmd;
	ledfb_pkg::status_t                   st;
	logic                                 out_kind;
	logic [ledfb_pkg::SYM_W-1:0]          out_symbol;
	logic [ledfb_pkg::COLOR_W-1:0]        out_color;

	ledfb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.func    (s_tuser),
		.st      (st),
		.s_tready(s_tready),
		.cmd     (cmd)
	);

	ledfb_dp #(
		.NUM_LEDS(NUM_LEDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.led_index (s_tdata[5:0]),
		.fill_count(s_tdata[12:6]),
		.color     (s_tdata[36:13]),
		.cmd       (cmd),
		.st        (st),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.out_kind  (out_kind),
		.out_symbol(out_symbol),
		.out_last  (m_tlast),
		.out_color (out_color)
	);

	assign m_tdata = {2'b00, out_color, out_symbol};
	assign m_tuser = out_kind;

	`ASSERT_IMPLIES(a_last_only_tick, clk, arst_n, m_tvalid && m_tlast, m_tuser[0] == 1'b0)
	`ASSERT_IMPLIES(a_read_no_symbol, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[5:0] == 6'd0)
	`ASSERT_IMPLIES(a_busy_no_accept, clk, arst_n, cmd.clr_wr || cmd.fill_wr, !s_tready)
	`ASSERT_NEXT(a_load_gives_valid, clk, arst_n, cmd.out_load, m_tvalid)

endmodule

FILE: test/led_frame_buffer_symbol_encoder_unit_test.sv
// Self-checking testbench for the LED frame buffer symbol encoder: a directed table, then
// random write/flush/tick frames, checked against a behavioral model of the strip buffer.
// Depends on ledfb_pkg and the led_frame_buffer_symbol_encoder_unit RTL.
`timescale 1ns / 1ps

module led_frame_buffer_symbol_encoder_unit_test;

	localparam int NUM_LEDS = ledfb_pkg::NUM_LEDS_DEF;
	localparam int TOTAL_REQUESTS = 700;
	localparam int TAIL_REQUESTS = 75;
	localparam int PAUSE_AFTER = 450;
	localparam int LONG_HOLD_CYCLES = 400;

	localparam logic [ledfb_pkg::FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
	localparam logic [ledfb_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [ledfb_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	typedef struct packed {
		logic [ledfb_pkg::FUNC_W-1:0] func;
		logic [ledfb_pkg::IDX_W-1:0] idx;
		logic [ledfb_pkg::CNT_W-1:0] count;
		logic [ledfb_pkg::COLOR_W-1:0] color;
	} strip_request_t;

	typedef struct packed {
		logic kind;
		logic [ledfb_pkg::SYM_W-1:0] sym;
		logic frame_end;
		logic [ledfb_pkg::COLOR_W-1:0] color;
	} strip_result_t;

	typedef struct packed {
		strip_request_t req;
		logic typed;
		logic has_result;
		strip_result_t res;
	} plan_row_t;

	localparam strip_result_t NO_RESULT = '0;
	localparam int PLAN_ROWS = 20;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{'{ledfb_pkg::FUNC_READ, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b1,
			'{KIND_COLOR, 6'd0, 1'b0, 24'h000000}},
		'{'{ledfb_pkg::FUNC_READ, 6'd63, 7'd0, 24'h000000}, 1'b1, 1'b1,
			'{KIND_COLOR, 6'd0, 1'b0, 24'h000000}},
		'{'{ledfb_pkg::FUNC_TICK, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_FLUSH, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b0, NO_RESULT},
		'{'{FUNC_SPARE_5, 6'd63, 7'd127, 24'hFFFFFF}, 1'b1, 1'b0, NO_RESULT},
		'{'{FUNC_SPARE_6, 6'd1, 7'd1, 24'h000001}, 1'b1, 1'b0, NO_RESULT},
		'{'{FUNC_SPARE_7, 6'd2, 7'd64, 24'h800000}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_FILL, 6'd3, 7'd0, 24'hFFFFFF}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_READ, 6'd3, 7'd0, 24'h000000}, 1'b1, 1'b1,
			'{KIND_COLOR, 6'd0, 1'b0, 24'h000000}},
		'{'{ledfb_pkg::FUNC_SET, 6'd0, 7'd0, 24'hFFFFFF}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_READ, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b1,
			'{KIND_COLOR, 6'd0, 1'b0, 24'hFFFFFF}},
		'{'{ledfb_pkg::FUNC_FLUSH, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_SET, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_FLUSH, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_TICK, 6'd0, 7'd0, 24'h000000}, 1'b1, 1'b1,
			'{KIND_SYMBOL, ledfb_pkg::SYM_PAIR0, 1'b0, 24'h000000}},
		'{'{ledfb_pkg::FUNC_FILL, 6'd62, 7'd127, 24'h5A5A5A}, 1'b0, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_READ, 6'd63, 7'd0, 24'h000000}, 1'b0, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_READ, 6'd61, 7'd0, 24'h000000}, 1'b0, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_SET, 6'd63, 7'd64, 24'h9C3F1B}, 1'b0, 1'b0, NO_RESULT},
		'{'{ledfb_pkg::FUNC_TICK, 6'd0, 7'd0, 24'h000000}, 1'b0, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;   // led_index[5:0], fill_count[12:6], color[36:13]
	logic [2:0] s_tuser = '0;    // func[2:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;        // symbol[5:0], read_color[29:6]
	logic [0:0] m_tuser;         // result_kind[0]
	logic m_tlast;

	logic [ledfb_pkg::COLOR_W-1:0] led_colors [NUM_LEDS];
	logic [ledfb_pkg::CNT_W-1:0] mark;
	logic [ledfb_pkg::CNT_W-1:0] frame_leds;
	logic [ledfb_pkg::IDX_W-1:0] out_led;
	logic [ledfb_pkg::PAIR_W-1:0] out_pair;
	logic frame_busy;

	strip_result_t pending_results [$];
	int requests_done = 0;
	int results_seen = 0;
	int mismatches = 0;
	logic tail_run = 1'b0;
	logic gap_phase = 1'b1;

	led_frame_buffer_symbol_encoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// Applies one request to the strip model; returns 1 when it yields a result.
	function automatic bit advance_strip(input strip_request_t req, output strip_result_t res);
		int stop;
		int sh;
		logic [ledfb_pkg::COLOR_W-1:0] pix;
		logic [1:0] pair_bits;
		logic [ledfb_pkg::SYM_W-1:0] sym;
		logic fin;
		res = NO_RESULT;
		case (req.func)
			ledfb_pkg::FUNC_SET: begin
				if (int'(req.idx) < NUM_LEDS) begin
					led_colors[req.idx] = req.color;
					if (int'(req.idx) + 1 > int'(mark))
						mark = ledfb_pkg::CNT_W'(int'(req.idx) + 1);
				end
				return 1'b0;
			end
			ledfb_pkg::FUNC_FILL: begin
				if (req.count == 0 || int'(req.idx) >= NUM_LEDS)
					return 1'b0;
				stop = int'(req.idx) + int'(req.count);
				if (stop > NUM_LEDS)
					stop = NUM_LEDS;
				for (int d = int'(req.idx); d < stop; d++)
					led_colors[d] = req.color;
				if (stop > int'(mark))
					mark = ledfb_pkg::CNT_W'(stop);
				return 1'b0;
			end
			ledfb_pkg::FUNC_FLUSH: begin
				if (frame_busy)
					return 1'b0;
				if (mark != 0) begin
					frame_leds = mark;
					out_led = '0;
					out_pair = '0;
					frame_busy = 1'b1;
				end
				mark = '0;
				return 1'b0;
			end
			ledfb_pkg::FUNC_TICK: begin
				if (!frame_busy)
					return 1'b0;
				pix = led_colors[out_led];
				sh = 22 - 2 * int'(out_pair);
				pair_bits = 2'(pix >> sh);
				case (pair_bits)
					2'd0: sym = ledfb_pkg::SYM_PAIR0;
					2'd1: sym = ledfb_pkg::SYM_PAIR1;
					2'd2: sym = ledfb_pkg::SYM_PAIR2;
					default: sym = ledfb_pkg::SYM_PAIR3;
				endcase
				fin = (out_pair == ledfb_pkg::PAIR_LAST)
					&& (int'(out_led) + 1 >= int'(frame_leds));
				if (out_pair == ledfb_pkg::PAIR_LAST) begin
					out_pair = '0;
					out_led = out_led + 1'b1;
				end else begin
					out_pair = out_pair + 1'b1;
				end
				if (fin) begin
					frame_busy = 1'b0;
					out_led = '0;
					out_pair = '0;
				end
				res = '{KIND_SYMBOL, sym, fin, 24'h000000};
				return 1'b1;
			end
			ledfb_pkg::FUNC_READ: begin
				res = '{KIND_COLOR, 6'd0, 1'b0,
					(int'(req.idx) < NUM_LEDS) ? led_colors[req.idx] : 24'h000000};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [ledfb_pkg::IDX_W-1:0] random_index();
		return ($urandom_range(0, 23) == 0) ? ledfb_pkg::IDX_W'($urandom_range(0, 63))
			: ledfb_pkg::IDX_W'($urandom_range(0, 5));
	endfunction

	function automatic strip_request_t random_write();
		strip_request_t req;
		req.func = $urandom_range(0, 1) ? ledfb_pkg::FUNC_FILL : ledfb_pkg::FUNC_SET;
		req.idx = random_index();
		req.count = ($urandom_range(0, 11) == 0) ? ledfb_pkg::CNT_W'($urandom_range(0, 127))
			: ledfb_pkg::CNT_W'($urandom_range(0, 3));
		req.color = ledfb_pkg::COLOR_W'($urandom());
		return req;
	endfunction

	function automatic strip_request_t random_item();
		strip_request_t req;
		req = random_write();
		req.func = ledfb_pkg::FUNC_W'($urandom_range(0, 7));
		if (req.func == ledfb_pkg::FUNC_READ)
			req.idx = ledfb_pkg::IDX_W'($urandom_range(0, 63));
		return req;
	endfunction

	task automatic issue_request(input strip_request_t req, input logic typed,
		input logic has_result, input strip_result_t typed_res);
		strip_result_t res;
		bit produced;
		if (!tail_run && gap_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tuser <= req.func;
		s_tdata <= {3'b000, req.color, req.count, req.idx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		produced = advance_strip(req, res);
		if (typed) begin
			produced = has_result;
			res = typed_res;
		end
		if (produced)
			pending_results.push_back(res);
		if (req.func <= ledfb_pkg::FUNC_READ)
			requests_done++;
		if (requests_done % 50 == 0)
			gap_phase = ($urandom_range(0, 2) != 0);
		tail_run = (requests_done >= TOTAL_REQUESTS - TAIL_REQUESTS);
	endtask

	initial begin : stimulus
		strip_request_t req;
		bit paused;
		paused = 1'b0;
		foreach (led_colors[i])
			led_colors[i] = '0;
		mark = '0;
		frame_leds = '0;
		out_led = '0;
		out_pair = '0;
		frame_busy = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < PLAN_ROWS; i++)
			issue_request(PLAN[i].req, PLAN[i].typed, PLAN[i].has_result, PLAN[i].res);
		while (requests_done < TOTAL_REQUESTS) begin
			if (!frame_busy) begin
				if ((!paused && requests_done >= PAUSE_AFTER)
					|| (!tail_run && $urandom_range(0, 39) == 0)) begin
					paused = 1'b1;
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_results.size() != 0);
				end
				repeat ($urandom_range(1, 4)) issue_request(random_write(), 1'b0, 1'b0, NO_RESULT);
				if ($urandom_range(0, 2) == 0) begin
					req = random_item();
					req.func = ledfb_pkg::FUNC_READ;
					issue_request(req, 1'b0, 1'b0, NO_RESULT);
				end
				if ($urandom_range(0, 7) == 0)
					issue_request(random_item(), 1'b0, 1'b0, NO_RESULT);
				req = random_item();
				req.func = ledfb_pkg::FUNC_FLUSH;
				issue_request(req, 1'b0, 1'b0, NO_RESULT);
			end else begin
				req = random_item();
				if ($urandom_range(0, 9) != 0)
					req.func = ledfb_pkg::FUNC_TICK;
				issue_request(req, 1'b0, 1'b0, NO_RESULT);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("[led_frame_buffer_symbol_encoder_unit] OK");
		else
			$display("[led_frame_buffer_symbol_encoder_unit] ERROR");
		$finish;
	end

	initial begin : result_sink
		bit long_hold_done;
		bit sink_calm;
		long_hold_done = 1'b0;
		sink_calm = 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) == 0)
				sink_calm = !sink_calm;
			if (!long_hold_done && results_seen >= 150) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!tail_run && !sink_calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		strip_result_t got;
		strip_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata[5:0], m_tlast, m_tdata[29:6]};
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result kind %0d symbol %h last %0d color %h",
					$time, got.kind, got.sym, got.frame_end, got.color);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.sym !== want.sym
					|| got.frame_end !== want.frame_end || got.color !== want.color) begin
					$display("%0t: expected kind %0d symbol %h last %0d color %h,",
						$time, want.kind, want.sym, want.frame_end, want.color,
						" got kind %0d symbol %h last %0d color %h",
						got.kind, got.sym, got.frame_end, got.color);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#12000000;
		$display("[led_frame_buffer_symbol_encoder_unit] ERROR");
		$finish;
	end

endmodule
